/* hw/rtl/alpbbf_pkg.sv */
// ----------------------------------------------------------------------------
// alpbbf_pkg
// Shared types, constants and the frame length table of the baseband framer.
// ----------------------------------------------------------------------------
package alpbbf_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PktPosW   = 8;
  localparam int unsigned FrmPosW   = 13;
  localparam int unsigned RateW     = 4;
  localparam int unsigned CntW      = 2;
  localparam int unsigned MaxRes    = 3;

  localparam logic [PktPosW-1:0] TsPacketLen = 8'd188;
  localparam logic [ByteW-1:0]   AlpTsHeader = 8'hE2;
  localparam logic [ByteW-1:0]   TsSync      = 8'h47;
  localparam logic [ByteW-1:0]   ModeBit     = 8'h80;
  localparam logic [RateW-1:0]   MaxRate     = 4'd11;
  localparam logic [FrmPosW-1:0] HeaderLen   = 13'd2;

  // configuration register indexes
  localparam logic CfgShortFrame = 1'b0;
  localparam logic CfgCodeRate   = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_header;
    logic             frame_end;
    logic             sync_error;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    result_t [MaxRes-1:0] res;   // res[0] leaves first
    logic [CntW-1:0]      cnt;
  } group_t;

  // frame length in bytes (kbch / 8), rate codes above the top act as the top
  function automatic logic [FrmPosW-1:0] frame_bytes(input logic short_frame,
                                                     input logic [RateW-1:0] rate_in);
    logic [RateW-1:0]   rate;
    logic [FrmPosW-1:0] len;
    rate = (rate_in > MaxRate) ? MaxRate : rate_in;
    len  = '0;
    if (short_frame) begin
      case (rate)
        4'd0:    len = 13'd249;
        4'd1:    len = 13'd384;
        4'd2:    len = 13'd519;
        4'd3:    len = 13'd654;
        4'd4:    len = 13'd789;
        4'd5:    len = 13'd924;
        4'd6:    len = 13'd1059;
        4'd7:    len = 13'd1194;
        4'd8:    len = 13'd1329;
        4'd9:    len = 13'd1464;
        4'd10:   len = 13'd1599;
        default: len = 13'd1734;
      endcase
    end else begin
      case (rate)
        4'd0:    len = 13'd1056;
        4'd1:    len = 13'd1596;
        4'd2:    len = 13'd2136;
        4'd3:    len = 13'd2676;
        4'd4:    len = 13'd3216;
        4'd5:    len = 13'd3756;
        4'd6:    len = 13'd4296;
        4'd7:    len = 13'd4836;
        4'd8:    len = 13'd5376;
        4'd9:    len = 13'd5916;
        4'd10:   len = 13'd6456;
        default: len = 13'd6996;
      endcase
    end
    return len;
  endfunction

endpackage

/* hw/rtl/alpbbf_core.sv */
// ----------------------------------------------------------------------------
// alpbbf_core
// Packet and frame position tracking, builds the result group of one byte.
// ----------------------------------------------------------------------------
module alpbbf_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [alpbbf_pkg::ByteW-1:0]        ts_byte_i,
  input  logic                                short_frame_i,
  input  logic [alpbbf_pkg::RateW-1:0]        code_rate_index_i,
  output alpbbf_pkg::group_t                  group_o
);

  logic [alpbbf_pkg::PktPosW-1:0] pkt_pos_q, pkt_pos_d;
  logic [alpbbf_pkg::FrmPosW-1:0] frm_pos_q, frm_pos_d;

  logic [alpbbf_pkg::FrmPosW-1:0] len;
  logic                           frame_start;
  logic                           pkt_start;
  logic [alpbbf_pkg::FrmPosW-1:0] frm_base;
  logic [alpbbf_pkg::FrmPosW:0]   frm_inc;
  logic [alpbbf_pkg::PktPosW:0]   pkt_inc;
  logic [alpbbf_pkg::FrmPosW-1:0] ptr;
  logic                           fend;
  alpbbf_pkg::result_t            hdr1, hdr2, dat;

  always_comb begin
    len         = alpbbf_pkg::frame_bytes(short_frame_i, code_rate_index_i);
    frame_start = (frm_pos_q == '0);
    pkt_start   = (pkt_pos_q == '0);
    frm_base    = frame_start ? alpbbf_pkg::HeaderLen : frm_pos_q;
    frm_inc     = {1'b0, frm_base} + 1'b1;
    pkt_inc     = {1'b0, pkt_pos_q} + 1'b1;
    fend        = (frm_inc >= {1'b0, len});

    // bytes still left of the packet in progress
    ptr = pkt_start ? '0
                    : alpbbf_pkg::FrmPosW'(alpbbf_pkg::TsPacketLen - pkt_pos_q);

    hdr1.out_byte    = alpbbf_pkg::ModeBit | {1'b0, ptr[6:0]};
    hdr1.is_header   = 1'b1;
    hdr1.frame_end   = 1'b0;
    hdr1.sync_error  = 1'b0;
    hdr1.last_of_run = 1'b0;

    hdr2.out_byte    = {ptr[12:7], 2'b00};
    hdr2.is_header   = 1'b1;
    hdr2.frame_end   = 1'b0;
    hdr2.sync_error  = 1'b0;
    hdr2.last_of_run = 1'b0;

    dat.out_byte    = pkt_start ? alpbbf_pkg::AlpTsHeader : ts_byte_i;
    dat.is_header   = 1'b0;
    dat.frame_end   = fend;
    dat.sync_error  = pkt_start && (ts_byte_i != alpbbf_pkg::TsSync);
    dat.last_of_run = 1'b1;

    if (frame_start) begin
      group_o.res[0] = hdr1;
      group_o.res[1] = hdr2;
      group_o.res[2] = dat;
      group_o.cnt    = alpbbf_pkg::CntW'(3);
    end else begin
      group_o.res[0] = dat;
      group_o.res[1] = dat;
      group_o.res[2] = dat;
      group_o.cnt    = alpbbf_pkg::CntW'(1);
    end

    pkt_pos_d = pkt_pos_q;
    frm_pos_d = frm_pos_q;
    if (accept_i) begin
      pkt_pos_d = (pkt_inc >= {1'b0, alpbbf_pkg::TsPacketLen}) ? '0 : pkt_inc[7:0];
      frm_pos_d = fend ? '0 : frm_inc[alpbbf_pkg::FrmPosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_pos_q <= '0;
      frm_pos_q <= '0;
    end else begin
      pkt_pos_q <= pkt_pos_d;
      frm_pos_q <= frm_pos_d;
    end
  end

endmodule

/* hw/rtl/alpbbf_outq.sv */
// ----------------------------------------------------------------------------
// alpbbf_outq
// Result register holding the group of one byte, hands out one result a cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module alpbbf_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  alpbbf_pkg::group_t  group_i,
  output logic                load_ok_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output alpbbf_pkg::result_t res_o
);

  alpbbf_pkg::result_t [alpbbf_pkg::MaxRes-1:0] res_q, res_d;
  logic [alpbbf_pkg::CntW-1:0]                  cnt_q, cnt_d;
  logic                                         pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // room once the last waiting result leaves in this cycle
  assign load_ok_o   = (cnt_q == '0) || ((cnt_q == alpbbf_pkg::CntW'(1)) && out_ready_i);
  assign res_o       = res_q[0];

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (pop) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      cnt_d    = cnt_q - 1'b1;
    end
    if (load_i) begin
      res_d = group_i.res;
      cnt_d = group_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

/* hw/rtl/alp_baseband_framer_top.sv */
// ----------------------------------------------------------------------------
// alp_baseband_framer_top
// Packs transport-stream bytes into baseband frames with a two-byte header.
// ----------------------------------------------------------------------------
// output: the first result of a byte is registered and valid in the cycle after the byte is taken
// throughput: one byte per cycle while out_ready_i is high; a frame-start
//   byte gives three results; input stalls while the result register drains
// reset: packet and frame positions and both config registers clear to zero
// ----------------------------------------------------------------------------
module alp_baseband_framer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ts_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_header_o,
  output logic       frame_end_o,
  output logic       sync_error_o,
  output logic       last_of_run_o
);

  logic                                short_frame_q;
  logic [alpbbf_pkg::RateW-1:0]        code_rate_q;
  logic                                accept;
  logic                                load_ok;
  alpbbf_pkg::group_t                  group;
  alpbbf_pkg::result_t                 res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = load_ok;
  assign accept      = in_valid_i && load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_frame_q <= 1'b0;
      code_rate_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        alpbbf_pkg::CfgShortFrame: short_frame_q <= cfg_data_i[0];
        alpbbf_pkg::CfgCodeRate:   code_rate_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  alpbbf_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .ts_byte_i         (ts_byte_i),
    .short_frame_i     (short_frame_q),
    .code_rate_index_i (code_rate_q),
    .group_o           (group)
  );

  alpbbf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .group_i     (group),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign out_byte_o    = res.out_byte;
  assign is_header_o   = res.is_header;
  assign frame_end_o   = res.frame_end;
  assign sync_error_o  = res.sync_error;
  assign last_of_run_o = res.last_of_run;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the baseband framer. Transport-stream bytes go in
// over valid/ready, the framer model or a typed row predicts every frame byte, and
// each output transaction is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

  localparam int HoldCycles = 80;

  typedef struct packed {
    logic [7:0]          ts;
    logic [1:0]          n_typed;
    alpbbf_pkg::result_t t0;
    alpbbf_pkg::result_t t1;
    alpbbf_pkg::result_t t2;
  } stim_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = alpbbf_pkg::CfgShortFrame;
  logic [3:0] cfg_data_i  = 4'h0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] ts_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       is_header_o;
  logic       frame_end_o;
  logic       sync_error_o;
  logic       last_of_run_o;

  // framer model state
  logic [0:0]  cfg_short = 1'b0;
  logic [3:0]  cfg_rate  = 4'd0;
  logic [7:0]  pkt_pos   = 8'd0;
  logic [12:0] frm_pos   = 13'd0;
  int unsigned kbch_bits [2][12] = '{
    '{8448, 12768, 17088, 21408, 25728, 30048, 34368, 38688, 43008, 47328, 51648, 55968},
    '{1992, 3072, 4152, 5232, 6312, 7392, 8472, 9552, 10632, 11712, 12792, 13872}
  };

  alpbbf_pkg::result_t expected_bytes [$];
  int                  bytes_checked = 0;
  int                  mismatches    = 0;
  alpbbf_pkg::result_t oldest;
  stim_row_t           dir_rows [16];

  int send_idle_pct = 8;
  int recv_idle_pct = 62;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  alp_baseband_framer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ts_byte_i    (ts_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .is_header_o  (is_header_o),
    .frame_end_o  (frame_end_o),
    .sync_error_o (sync_error_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic alpbbf_pkg::result_t mk(input logic [7:0] b, input logic hdr,
                                             input logic fend, input logic serr,
                                             input logic last);
    return '{b, hdr, fend, serr, last};
  endfunction

  // frame bytes caused by one transport-stream byte, advances the model state
  function automatic int frame_ts_byte(input logic [7:0] b,
                                       output alpbbf_pkg::result_t [2:0] res);
    logic [12:0] ptr;
    logic [7:0]  data;
    logic        serr;
    logic        fend;
    int          len;
    int          n;
    len = kbch_bits[cfg_short][(cfg_rate > 4'd11) ? 11 : cfg_rate] / 8;
    n   = 0;
    res = '0;
    if (frm_pos == 13'd0) begin
      ptr    = (pkt_pos == 8'd0) ? 13'd0 : 13'(alpbbf_pkg::TsPacketLen - pkt_pos);
      res[0] = mk(alpbbf_pkg::ModeBit | {1'b0, ptr[6:0]}, 1'b1, 1'b0, 1'b0, 1'b0);
      res[1] = mk(8'((ptr >> 5) & 13'h0FC), 1'b1, 1'b0, 1'b0, 1'b0);
      n       = 2;
      frm_pos = 13'd2;
    end
    if (pkt_pos == 8'd0) begin
      data = alpbbf_pkg::AlpTsHeader;
      serr = (b != alpbbf_pkg::TsSync);
    end else begin
      data = b;
      serr = 1'b0;
    end
    pkt_pos = (pkt_pos + 1 >= alpbbf_pkg::TsPacketLen) ? 8'd0 : pkt_pos + 8'd1;
    // a shrunken frame length may already have been passed
    fend    = (frm_pos + 1 >= len);
    frm_pos = fend ? 13'd0 : frm_pos + 13'd1;
    res[n]  = mk(data, 1'b0, fend, serr, 1'b1);
    return n + 1;
  endfunction

  task automatic send_ts_byte(input logic [7:0] b, input int n_typed,
                              input alpbbf_pkg::result_t [2:0] typed);
    alpbbf_pkg::result_t [2:0] res;
    int                        n;
    int                        k;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ts_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    n = frame_ts_byte(b, res);
    if (n_typed != 0) begin
      res = typed;
      n   = n_typed;
    end
    for (k = 0; k < n; k++) expected_bytes.push_back(res[k]);
  endtask

  task automatic send_random(input int count);
    logic [7:0] b;
    repeat (count) begin
      if (pkt_pos == 8'd0 && $urandom_range(0, 9) != 0) b = alpbbf_pkg::TsSync;
      else b = 8'($urandom_range(0, 255));
      send_ts_byte(b, 0, '0);
    end
  endtask

  task automatic flush_results();
    in_valid_i <= 1'b0;
    while (bytes_checked < expected_bytes.size()) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic configure(input logic [3:0] short_val, input logic [3:0] rate_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= alpbbf_pkg::CfgShortFrame;
    cfg_data_i  <= short_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_short   = short_val[0];
    cfg_index_i <= alpbbf_pkg::CfgCodeRate;
    cfg_data_i  <= rate_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_rate    = rate_val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0h want %0h", bytes_checked, what, got, want);
    mismatches++;
  endtask

  // receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bytes_checked >= expected_bytes.size()) begin
        report_mismatch("unexpected transaction, byte", out_byte_o, 0);
      end else begin
        oldest = expected_bytes[bytes_checked];
        if (out_byte_o != oldest.out_byte)
          report_mismatch("out_byte", out_byte_o, oldest.out_byte);
        if (is_header_o != oldest.is_header)
          report_mismatch("is_header", is_header_o, oldest.is_header);
        if (frame_end_o != oldest.frame_end)
          report_mismatch("frame_end", frame_end_o, oldest.frame_end);
        if (sync_error_o != oldest.sync_error)
          report_mismatch("sync_error", sync_error_o, oldest.sync_error);
        if (last_of_run_o != oldest.last_of_run)
          report_mismatch("last_of_run", last_of_run_o, oldest.last_of_run);
        bytes_checked++;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    dir_rows = '{
      // bad sync byte at reset, frame opens with a zero pointer
      '{8'hB8, 2'd3, mk(alpbbf_pkg::ModeBit, 1'b1, 1'b0, 1'b0, 1'b0),
        mk(8'h00, 1'b1, 1'b0, 1'b0, 1'b0),
        mk(alpbbf_pkg::AlpTsHeader, 1'b0, 1'b0, 1'b1, 1'b1)},
      // sync value inside a packet passes through untouched
      '{8'h47, 2'd1, mk(8'h47, 1'b0, 1'b0, 1'b0, 1'b1), '0, '0},
      '{8'h00, 2'd1, mk(8'h00, 1'b0, 1'b0, 1'b0, 1'b1), '0, '0},
      '{8'hFF, 2'd1, mk(8'hFF, 1'b0, 1'b0, 1'b0, 1'b1), '0, '0},
      '{8'h01, 2'd0, '0, '0, '0},
      '{8'h02, 2'd0, '0, '0, '0},
      '{8'h04, 2'd0, '0, '0, '0},
      '{8'h08, 2'd0, '0, '0, '0},
      '{8'h10, 2'd0, '0, '0, '0},
      '{8'h20, 2'd0, '0, '0, '0},
      '{8'h40, 2'd0, '0, '0, '0},
      '{8'h80, 2'd0, '0, '0, '0},
      '{8'hFE, 2'd0, '0, '0, '0},
      '{8'h7F, 2'd0, '0, '0, '0},
      '{8'hE2, 2'd0, '0, '0, '0},
      '{8'h55, 2'd0, '0, '0, '0}
    };
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_ts_byte(dir_rows[i].ts, dir_rows[i].n_typed,
                   {dir_rows[i].t2, dir_rows[i].t1, dir_rows[i].t0});
    flush_results();

    // upper data bits of the frame size write are ignored: normal table, top rate
    configure(4'hE, 4'd11);
    send_random(120);
    hold_reqs++;
    send_random(100);
    while (frm_pos < 13'd250) send_random(1);
    flush_results();

    send_idle_pct = 62;
    recv_idle_pct = 8;
    // short table, lowest rate: frame end now overdue, next byte closes it
    configure(4'h1, 4'h0);
    send_random(60);
    flush_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // rate code above the top acts as the top rate
    configure(4'h1, 4'hF);
    send_random(60);
    flush_results();

    if (mismatches == 0 && bytes_checked == expected_bytes.size()) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/alpbbf_pkg.sv
hw/rtl/alpbbf_core.sv
hw/rtl/alpbbf_outq.sv
hw/rtl/alp_baseband_framer_top.sv
verif/tb.sv
